// ===== hdl/hrbp_pkg.sv =====
// shared types, constants and character helpers for the http request byte parser
package hrbp_pkg;

    // default width of the content-length accumulator
    localparam int LENGTH_WIDTH_DEF = 24;

    // parser states
    typedef enum logic [4:0] {
        ST_START, ST_METHOD, ST_BEFORE_URI, ST_URI, ST_BEFORE_KEY, ST_KEY,
        ST_BEFORE_VAL, ST_VAL, ST_BEFORE_PROTO, ST_PROTO, ST_BEFORE_VER, ST_VER,
        ST_VER_DOT, ST_HKEY, ST_BEFORE_COLON, ST_AFTER_COLON, ST_HVAL, ST_CR,
        ST_CRLF, ST_CRLFCR, ST_BODY_LEN, ST_BODY_END, ST_COMPLETE, ST_INVALID,
        ST_INV_METHOD, ST_INV_URI, ST_INV_VERSION, ST_INV_HEADER
    } t_state;

    // field tags carried with every byte
    typedef enum logic [3:0] {
        TAG_NONE, TAG_METHOD, TAG_PATH, TAG_QKEY, TAG_QVAL, TAG_PROTO,
        TAG_VERSION, TAG_HKEY, TAG_HVAL, TAG_BODY
    } t_tag;

    // request status codes
    typedef enum logic [2:0] {
        STAT_PARSING, STAT_COMPLETE, STAT_INVALID, STAT_BAD_METHOD,
        STAT_BAD_URI, STAT_BAD_VERSION, STAT_BAD_HEADER
    } t_status;

    // narrow control context of the parser
    typedef struct packed {
        t_state     state;
        logic [3:0] key_idx;
        logic       key_match;
        logic       in_len;
        logic       len_seen;
        logic       len_neg;
        logic       len_done;
        logic       len_started;
        logic       header_done;
        logic       body_begun;
    } t_ctx;

    localparam t_ctx CTX_RESET = '{
        state: ST_START, key_idx: 4'd0, key_match: 1'b0, in_len: 1'b0,
        len_seen: 1'b0, len_neg: 1'b0, len_done: 1'b0, len_started: 1'b0,
        header_done: 1'b0, body_begun: 1'b0
    };

    // character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QM    = 8'h3F;

    // length of the "Content-Length" key
    localparam logic [3:0] KEY_LEN = 4'd14;

    // one character of "Content-Length"
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h43; // C
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6E; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h4C; // L
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6E; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // character classes
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// ===== hdl/hrbp_if.sv =====
// handshake interfaces for the request byte words and the result words
interface hrbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output byte_value, output first_byte,
                    output last_byte, input ready);
    modport sink   (input valid, input byte_value, input first_byte,
                    input last_byte, output ready);
endinterface

interface hrbp_out_if #(
    parameter int LENGTH_WIDTH = hrbp_pkg::LENGTH_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [7:0]              byte_echo;
    logic [3:0]              field_tag;
    logic                    field_opens;
    logic                    field_closes;
    logic [2:0]              parse_status;
    logic                    length_header_seen;
    logic [LENGTH_WIDTH-1:0] body_length;

    modport source (output valid, output byte_echo, output field_tag,
                    output field_opens, output field_closes, output parse_status,
                    output length_header_seen, output body_length, input ready);
    modport sink   (input valid, input byte_echo, input field_tag,
                    input field_opens, input field_closes, input parse_status,
                    input length_header_seen, input body_length, output ready);
endinterface

// ===== hdl/hrbp_step.sv =====
// per-byte transition logic of the request parser
module hrbp_step #(
    parameter int LENGTH_WIDTH = hrbp_pkg::LENGTH_WIDTH_DEF
) (
    input  hrbp_pkg::t_ctx          i_ctx,
    input  logic [LENGTH_WIDTH-1:0] i_acc,
    input  logic [LENGTH_WIDTH-1:0] i_rem,
    input  logic [7:0]              i_byte,
    input  logic                    i_first,
    input  logic                    i_last,
    output hrbp_pkg::t_ctx          o_ctx,
    output logic [LENGTH_WIDTH-1:0] o_acc,
    output logic [LENGTH_WIDTH-1:0] o_rem,
    output hrbp_pkg::t_tag          o_tag,
    output logic                    o_opens,
    output logic                    o_closes,
    output hrbp_pkg::t_status       o_status,
    output logic [LENGTH_WIDTH-1:0] o_blen
);

    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = {LENGTH_WIDTH{1'b1}};

    hrbp_pkg::t_ctx          ctx_c;
    logic [LENGTH_WIDTH-1:0] acc_c;
    logic [LENGTH_WIDTH-1:0] rem_c;
    logic [LENGTH_WIDTH-1:0] rem_dec;

    logic [3:0]              ks_idx_in;
    logic                    ks_match_in;
    logic                    ks_hit;
    logic [3:0]              ks_idx;
    logic                    ke_hit;

    logic [LENGTH_WIDTH+3:0] acc_wide;
    logic [LENGTH_WIDTH-1:0] acc_sat;
    logic                    vs_done;
    logic                    vs_started;
    logic                    vs_neg;
    logic [LENGTH_WIDTH-1:0] vs_acc;

    // a first byte starts from the reset context
    always_comb begin
        ctx_c = i_first ? hrbp_pkg::CTX_RESET : i_ctx;
        acc_c = i_first ? '0 : i_acc;
        rem_c = i_first ? '0 : i_rem;
    end

    // header key compare against content-length, restarted on a new key
    always_comb begin
        ks_idx_in   = (ctx_c.state == hrbp_pkg::ST_CRLF) ? 4'd0 : ctx_c.key_idx;
        ks_match_in = (ctx_c.state == hrbp_pkg::ST_CRLF) ? 1'b1 : ctx_c.key_match;
        ks_hit      = ks_match_in && (ks_idx_in < hrbp_pkg::KEY_LEN)
                      && (hrbp_pkg::key_char(ks_idx_in) == i_byte);
        ks_idx      = ks_hit ? ks_idx_in + 4'd1 : ks_idx_in;
        ke_hit      = ctx_c.key_match && (ctx_c.key_idx == hrbp_pkg::KEY_LEN)
                      && !ctx_c.len_seen;
    end

    // decimal accumulate with saturation: acc*10 + digit
    always_comb begin
        acc_wide = ({4'd0, acc_c} << 3) + ({4'd0, acc_c} << 1)
                   + {{LENGTH_WIDTH{1'b0}}, i_byte[3:0]};
        acc_sat  = (acc_wide > {4'd0, LEN_MAX}) ? LEN_MAX
                                                : acc_wide[LENGTH_WIDTH-1:0];
    end

    // number scan of the content-length value
    always_comb begin
        vs_done    = ctx_c.len_done;
        vs_started = ctx_c.len_started;
        vs_neg     = ctx_c.len_neg;
        vs_acc     = acc_c;
        if (ctx_c.in_len && !ctx_c.len_done) begin
            priority if (!ctx_c.len_started && hrbp_pkg::is_space(i_byte)) begin
                vs_started = 1'b0;
            end else if (!ctx_c.len_started
                         && ((i_byte == hrbp_pkg::CH_PLUS)
                             || (i_byte == hrbp_pkg::CH_MINUS))) begin
                vs_started = 1'b1;
                vs_neg     = (i_byte == hrbp_pkg::CH_MINUS);
            end else begin
                vs_started = 1'b1;
                if (hrbp_pkg::is_digit(i_byte)) begin
                    vs_acc = acc_sat;
                end else begin
                    vs_done = 1'b1;
                end
            end
        end
    end

    assign rem_dec = rem_c - {{(LENGTH_WIDTH-1){1'b0}}, (rem_c != '0)};

    // state transition and byte tagging
    always_comb begin
        o_ctx    = ctx_c;
        o_acc    = acc_c;
        o_rem    = rem_c;
        o_tag    = hrbp_pkg::TAG_NONE;
        o_opens  = 1'b0;
        o_closes = 1'b0;
        unique case (ctx_c.state)
            hrbp_pkg::ST_START: begin
                if ((i_byte == hrbp_pkg::CH_CR) || (i_byte == hrbp_pkg::CH_LF)
                    || hrbp_pkg::is_blank(i_byte)) begin
                    o_ctx.state = hrbp_pkg::ST_START;
                end else if (hrbp_pkg::is_upper(i_byte)) begin
                    o_tag = hrbp_pkg::TAG_METHOD; o_opens = 1'b1;
                    o_ctx.state = hrbp_pkg::ST_METHOD;
                end else begin
                    o_ctx.state = hrbp_pkg::ST_INVALID;
                end
            end
            hrbp_pkg::ST_METHOD: begin
                if (hrbp_pkg::is_upper(i_byte)) begin
                    o_tag = hrbp_pkg::TAG_METHOD;
                end else if (hrbp_pkg::is_blank(i_byte)) begin
                    o_closes = 1'b1; o_ctx.state = hrbp_pkg::ST_BEFORE_URI;
                end else begin
                    o_ctx.state = hrbp_pkg::ST_INV_METHOD;
                end
            end
            hrbp_pkg::ST_BEFORE_URI: begin
                if (i_byte == hrbp_pkg::CH_SLASH) begin
                    o_tag = hrbp_pkg::TAG_PATH; o_opens = 1'b1;
                    o_ctx.state = hrbp_pkg::ST_URI;
                end else if (!hrbp_pkg::is_blank(i_byte)) begin
                    o_ctx.state = hrbp_pkg::ST_INVALID;
                end
            end
            hrbp_pkg::ST_URI: begin
                if (i_byte == hrbp_pkg::CH_QM) begin
                    o_closes = 1'b1; o_ctx.state = hrbp_pkg::ST_BEFORE_KEY;
                end else if (hrbp_pkg::is_blank(i_byte)) begin
                    o_closes = 1'b1; o_ctx.state = hrbp_pkg::ST_BEFORE_PROTO;
                end else begin
                    o_tag = hrbp_pkg::TAG_PATH;
                end
            end
            hrbp_pkg::ST_BEFORE_KEY: begin
                if (hrbp_pkg::is_blank(i_byte) || (i_byte == hrbp_pkg::CH_LF)
                    || (i_byte == hrbp_pkg::CH_CR)) begin
                    o_ctx.state = hrbp_pkg::ST_INV_URI;
                end else begin
                    o_tag = hrbp_pkg::TAG_QKEY; o_opens = 1'b1;
                    o_ctx.state = hrbp_pkg::ST_KEY;
                end
            end
            hrbp_pkg::ST_KEY: begin
                if (i_byte == hrbp_pkg::CH_EQ) begin
                    o_closes = 1'b1; o_ctx.state = hrbp_pkg::ST_BEFORE_VAL;
                end else if (hrbp_pkg::is_blank(i_byte)) begin
                    o_ctx.state = hrbp_pkg::ST_INV_URI;
                end else begin
                    o_tag = hrbp_pkg::TAG_QKEY;
                end
            end
            hrbp_pkg::ST_BEFORE_VAL: begin
                if (hrbp_pkg::is_blank(i_byte) || (i_byte == hrbp_pkg::CH_LF)
                    || (i_byte == hrbp_pkg::CH_CR)) begin
                    o_ctx.state = hrbp_pkg::ST_INV_URI;
                end else begin
                    o_tag = hrbp_pkg::TAG_QVAL; o_opens = 1'b1;
                    o_ctx.state = hrbp_pkg::ST_VAL;
                end
            end
            hrbp_pkg::ST_VAL: begin
                if (i_byte == hrbp_pkg::CH_AMP) begin
                    o_closes = 1'b1; o_ctx.state = hrbp_pkg::ST_BEFORE_KEY;
                end else if (hrbp_pkg::is_blank(i_byte)) begin
                    o_closes = 1'b1; o_ctx.state = hrbp_pkg::ST_BEFORE_PROTO;
                end else begin
                    o_tag = hrbp_pkg::TAG_QVAL;
                end
            end
            hrbp_pkg::ST_BEFORE_PROTO: begin
                if (!hrbp_pkg::is_blank(i_byte)) begin
                    o_tag = hrbp_pkg::TAG_PROTO; o_opens = 1'b1;
                    o_ctx.state = hrbp_pkg::ST_PROTO;
                end
            end
            hrbp_pkg::ST_PROTO: begin
                if (i_byte == hrbp_pkg::CH_SLASH) begin
                    o_closes = 1'b1; o_ctx.state = hrbp_pkg::ST_BEFORE_VER;
                end else begin
                    o_tag = hrbp_pkg::TAG_PROTO;
                end
            end
            hrbp_pkg::ST_BEFORE_VER: begin
                if (hrbp_pkg::is_digit(i_byte)) begin
                    o_tag = hrbp_pkg::TAG_VERSION; o_opens = 1'b1;
                    o_ctx.state = hrbp_pkg::ST_VER;
                end else begin
                    o_ctx.state = hrbp_pkg::ST_INV_VERSION;
                end
            end
            hrbp_pkg::ST_VER: begin
                if (i_byte == hrbp_pkg::CH_CR) begin
                    o_closes = 1'b1; o_ctx.state = hrbp_pkg::ST_CR;
                end else if (i_byte == hrbp_pkg::CH_DOT) begin
                    o_tag = hrbp_pkg::TAG_VERSION; o_ctx.state = hrbp_pkg::ST_VER_DOT;
                end else if (hrbp_pkg::is_digit(i_byte)) begin
                    o_tag = hrbp_pkg::TAG_VERSION;
                end else begin
                    o_ctx.state = hrbp_pkg::ST_INV_VERSION;
                end
            end
            hrbp_pkg::ST_VER_DOT: begin
                if (hrbp_pkg::is_digit(i_byte)) begin
                    o_tag = hrbp_pkg::TAG_VERSION; o_ctx.state = hrbp_pkg::ST_VER;
                end else begin
                    o_ctx.state = hrbp_pkg::ST_INV_VERSION;
                end
            end
            hrbp_pkg::ST_HKEY: begin
                if (hrbp_pkg::is_blank(i_byte) || (i_byte == hrbp_pkg::CH_COLON)) begin
                    o_closes     = 1'b1;
                    o_ctx.in_len = ke_hit;
                    if (ke_hit) begin
                        o_ctx.len_neg     = 1'b0;
                        o_ctx.len_done    = 1'b0;
                        o_ctx.len_started = 1'b0;
                        o_acc             = '0;
                    end
                    o_ctx.state = (i_byte == hrbp_pkg::CH_COLON)
                                  ? hrbp_pkg::ST_AFTER_COLON : hrbp_pkg::ST_BEFORE_COLON;
                end else begin
                    o_tag           = hrbp_pkg::TAG_HKEY;
                    o_ctx.key_idx   = ks_idx;
                    o_ctx.key_match = ks_hit;
                end
            end
            hrbp_pkg::ST_BEFORE_COLON: begin
                if (i_byte == hrbp_pkg::CH_COLON) begin
                    o_ctx.state = hrbp_pkg::ST_AFTER_COLON;
                end else if (!hrbp_pkg::is_blank(i_byte)) begin
                    o_ctx.state = hrbp_pkg::ST_INV_HEADER;
                end
            end
            hrbp_pkg::ST_AFTER_COLON, hrbp_pkg::ST_HVAL: begin
                if ((ctx_c.state == hrbp_pkg::ST_HVAL) && (i_byte == hrbp_pkg::CH_CR)) begin
                    o_closes = 1'b1;
                    if (ctx_c.in_len) begin
                        o_ctx.len_seen = 1'b1;
                        o_ctx.in_len   = 1'b0;
                    end
                    o_ctx.state = hrbp_pkg::ST_CR;
                end else if ((ctx_c.state == hrbp_pkg::ST_HVAL)
                             || !hrbp_pkg::is_blank(i_byte)) begin
                    // carriage return right after the colon opens the value
                    o_tag             = hrbp_pkg::TAG_HVAL;
                    o_opens           = (ctx_c.state == hrbp_pkg::ST_AFTER_COLON);
                    o_ctx.len_done    = vs_done;
                    o_ctx.len_started = vs_started;
                    o_ctx.len_neg     = vs_neg;
                    o_acc             = vs_acc;
                    o_ctx.state       = hrbp_pkg::ST_HVAL;
                end
            end
            hrbp_pkg::ST_CR: begin
                o_ctx.state = (i_byte == hrbp_pkg::CH_LF) ? hrbp_pkg::ST_CRLF
                                                          : hrbp_pkg::ST_INVALID;
            end
            hrbp_pkg::ST_CRLF: begin
                if (i_byte == hrbp_pkg::CH_CR) begin
                    o_ctx.state = hrbp_pkg::ST_CRLFCR;
                end else if (hrbp_pkg::is_blank(i_byte)) begin
                    o_ctx.state = hrbp_pkg::ST_INVALID;
                end else begin
                    o_tag           = hrbp_pkg::TAG_HKEY; o_opens = 1'b1;
                    o_ctx.key_idx   = ks_idx;
                    o_ctx.key_match = ks_hit;
                    o_ctx.in_len    = 1'b0;
                    o_ctx.state     = hrbp_pkg::ST_HKEY;
                end
            end
            hrbp_pkg::ST_CRLFCR: begin
                if (i_byte != hrbp_pkg::CH_LF) begin
                    o_ctx.state = hrbp_pkg::ST_INV_HEADER;
                end else begin
                    o_ctx.header_done = 1'b1;
                    o_ctx.body_begun  = 1'b0;
                    priority if (ctx_c.len_seen) begin
                        if (!ctx_c.len_neg && (acc_c != '0)) begin
                            o_rem       = acc_c;
                            o_ctx.state = hrbp_pkg::ST_BODY_LEN;
                        end else begin
                            o_ctx.state = hrbp_pkg::ST_COMPLETE;
                        end
                    end else if (i_last) begin
                        o_ctx.state = hrbp_pkg::ST_COMPLETE;
                    end else begin
                        o_ctx.state = hrbp_pkg::ST_BODY_END;
                    end
                end
            end
            hrbp_pkg::ST_BODY_LEN: begin
                o_tag            = hrbp_pkg::TAG_BODY;
                o_opens          = !ctx_c.body_begun;
                o_ctx.body_begun = 1'b1;
                o_rem            = rem_dec;
                if (rem_dec == '0) begin
                    o_ctx.state = hrbp_pkg::ST_COMPLETE;
                end
            end
            hrbp_pkg::ST_BODY_END: begin
                o_tag            = hrbp_pkg::TAG_BODY;
                o_opens          = !ctx_c.body_begun;
                o_ctx.body_begun = 1'b1;
                if (i_last) begin
                    o_ctx.state = hrbp_pkg::ST_COMPLETE;
                end
            end
            // finished or rejected: hold until a new request
            default: begin
                o_ctx.state = ctx_c.state;
            end
        endcase
    end

    // status from the state just reached
    always_comb begin
        unique case (o_ctx.state)
            hrbp_pkg::ST_COMPLETE:    o_status = hrbp_pkg::STAT_COMPLETE;
            hrbp_pkg::ST_INVALID:     o_status = hrbp_pkg::STAT_INVALID;
            hrbp_pkg::ST_INV_METHOD:  o_status = hrbp_pkg::STAT_BAD_METHOD;
            hrbp_pkg::ST_INV_URI:     o_status = hrbp_pkg::STAT_BAD_URI;
            hrbp_pkg::ST_INV_VERSION: o_status = hrbp_pkg::STAT_BAD_VERSION;
            hrbp_pkg::ST_INV_HEADER:  o_status = hrbp_pkg::STAT_BAD_HEADER;
            default:                  o_status = hrbp_pkg::STAT_PARSING;
        endcase
    end

    // body length shows once the header block has ended, if a non-negative length header was seen
    assign o_blen = (o_ctx.header_done && o_ctx.len_seen && !o_ctx.len_neg) ? o_acc : '0;

endmodule

// ===== hdl/http_request_byte_parser_top.sv =====
// top level of the http request byte parser: context registers and result register
//
//  channel  | dir | word                                   | accepted when
//  ---------+-----+----------------------------------------+------------------
//  i_req    | in  | byte_value, first_byte, last_byte      | valid && ready
//  o_res    | out | byte_echo, tag, opens, closes, status, | valid && ready
//           |     | length_header_seen, body_length        |
//
// one byte per cycle unless the output stalls; its result word is offered in the next cycle
// the per-byte transition is one pass of hrbp_step between the context and result registers
// i_req.ready is high while the result register is empty or being taken this cycle
// a stalled result holds the input back; no word is dropped or repeated
// synchronous active-low reset returns the parser to the start state
module http_request_byte_parser_top #(
    parameter int LENGTH_WIDTH = hrbp_pkg::LENGTH_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hrbp_in_if.sink          i_req,
    hrbp_out_if.source       o_res
);

    hrbp_pkg::t_ctx          r_ctx;
    logic [LENGTH_WIDTH-1:0] r_acc;
    logic [LENGTH_WIDTH-1:0] r_rem;

    hrbp_pkg::t_ctx          n_ctx;
    logic [LENGTH_WIDTH-1:0] n_acc;
    logic [LENGTH_WIDTH-1:0] n_rem;
    hrbp_pkg::t_tag          n_tag;
    logic                    n_opens;
    logic                    n_closes;
    hrbp_pkg::t_status       n_status;
    logic [LENGTH_WIDTH-1:0] n_blen;

    logic                    r_out_valid;
    logic [7:0]              r_echo;
    hrbp_pkg::t_tag          r_tag;
    logic                    r_opens;
    logic                    r_closes;
    hrbp_pkg::t_status       r_status;
    logic                    r_seen;
    logic [LENGTH_WIDTH-1:0] r_blen;

    logic                    in_take;

    // result register empty or draining
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign in_take     = i_req.valid && i_req.ready;

    // per-byte transition
    hrbp_step #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_step (
        .i_ctx    (r_ctx),
        .i_acc    (r_acc),
        .i_rem    (r_rem),
        .i_byte   (i_req.byte_value),
        .i_first  (i_req.first_byte),
        .i_last   (i_req.last_byte),
        .o_ctx    (n_ctx),
        .o_acc    (n_acc),
        .o_rem    (n_rem),
        .o_tag    (n_tag),
        .o_opens  (n_opens),
        .o_closes (n_closes),
        .o_status (n_status),
        .o_blen   (n_blen)
    );

    // parser context
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx <= hrbp_pkg::CTX_RESET;
            r_acc <= '0;
            r_rem <= '0;
        end else if (in_take) begin
            r_ctx <= n_ctx;
            r_acc <= n_acc;
            r_rem <= n_rem;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_echo   <= i_req.byte_value;
            r_tag    <= n_tag;
            r_opens  <= n_opens;
            r_closes <= n_closes;
            r_status <= n_status;
            r_seen   <= n_ctx.len_seen;
            r_blen   <= n_blen;
        end
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.byte_echo          = r_echo;
    assign o_res.field_tag          = r_tag;
    assign o_res.field_opens        = r_opens;
    assign o_res.field_closes       = r_closes;
    assign o_res.parse_status       = r_status;
    assign o_res.length_header_seen = r_seen;
    assign o_res.body_length        = r_blen;

endmodule

// ===== hdl/hrbp_check.sv =====
// port-level checker for the http request byte parser and its bind
module hrbp_check #(
    parameter int LENGTH_WIDTH = hrbp_pkg::LENGTH_WIDTH_DEF
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [3:0]              i_tag,
    input logic                    i_closes,
    input logic [2:0]              i_status,
    input logic [LENGTH_WIDTH-1:0] i_blen
);

    // a result word stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result word withdrawn before it was taken");

    // every accepted byte yields a result word in the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("accepted byte produced no result word");

    // no result word without an accepted byte
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !(i_in_valid && i_in_ready)) |=> !i_out_valid)
        else $error("result word appeared without an accepted byte");

    // body bytes only occur while parsing or at completion, never as a delimiter
    a_body_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_tag == hrbp_pkg::TAG_BODY)) |->
        (!i_closes && ((i_status == hrbp_pkg::STAT_PARSING)
                       || (i_status == hrbp_pkg::STAT_COMPLETE))))
        else $error("body byte with delimiter flag or error status");

    // a body length is reported only while parsing, at completion or with a bad header status
    a_blen_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_blen != '0)) |->
        ((i_status == hrbp_pkg::STAT_PARSING) || (i_status == hrbp_pkg::STAT_COMPLETE)
         || (i_status == hrbp_pkg::STAT_BAD_HEADER)))
        else $error("body length reported with an unexpected status");

endmodule

bind http_request_byte_parser_top hrbp_check #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
) u_hrbp_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_tag       (o_res.field_tag),
    .i_closes    (o_res.field_closes),
    .i_status    (o_res.parse_status),
    .i_blen      (o_res.body_length)
);

// ===== tb/sv/hrbp_result_checker.sv =====
// watches both channels, predicts each result word of the byte parser and compares it
module hrbp_result_checker
    import hrbp_pkg::*;
#(
    parameter int LW = LENGTH_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    hrbp_in_if   i_req,
    hrbp_out_if  i_res,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked,
    output int   o_completed,
    output int   o_rejected
);

    // expected result word
    typedef struct packed {
        logic [7:0]    echo;
        t_tag          tag;
        logic          opens;
        logic          closes;
        t_status       status;
        logic          len_seen;
        logic [LW-1:0] blen;
    } t_result_word;

    localparam logic [8*14-1:0] LEN_KEY = "Content-Length";
    localparam longint unsigned LEN_MAX = (64'd1 << LW) - 64'd1;

    // parser model state
    t_state        pst;
    logic [3:0]    key_idx;
    logic          key_match;
    logic          in_len;
    logic          len_seen;
    logic          len_neg;
    logic          len_done;
    logic          len_started;
    logic          hdr_done;
    logic          body_begun;
    logic [LW-1:0] len_acc;
    logic [LW-1:0] body_left;

    t_result_word due_results[$];
    int           err_count;
    int           checked_n;
    int           completed_n;
    int           rejected_n;

    // character classes
    function automatic logic blank_ch(input logic [7:0] c);
        return c == CH_SP || c == CH_TAB;
    endfunction

    function automatic logic upper_ch(input logic [7:0] c);
        return c >= "A" && c <= "Z";
    endfunction

    function automatic logic digit_ch(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic space_ch(input logic [7:0] c);
        return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [7:0] key_letter(input logic [3:0] idx);
        return LEN_KEY[8*(13-int'(idx)) +: 8];
    endfunction

    function automatic t_status status_of(input t_state s);
        case (s)
            ST_COMPLETE:    return STAT_COMPLETE;
            ST_INVALID:     return STAT_INVALID;
            ST_INV_METHOD:  return STAT_BAD_METHOD;
            ST_INV_URI:     return STAT_BAD_URI;
            ST_INV_VERSION: return STAT_BAD_VERSION;
            ST_INV_HEADER:  return STAT_BAD_HEADER;
            default:        return STAT_PARSING;
        endcase
    endfunction

    task automatic clear_parser();
        pst         = ST_START;
        key_idx     = '0;
        key_match   = 1'b0;
        in_len      = 1'b0;
        len_seen    = 1'b0;
        len_neg     = 1'b0;
        len_done    = 1'b0;
        len_started = 1'b0;
        hdr_done    = 1'b0;
        body_begun  = 1'b0;
        len_acc     = '0;
        body_left   = '0;
    endtask

    // running compare of a header key against the length key
    task automatic key_advance(input logic [7:0] c);
        if (key_match && key_idx < KEY_LEN && key_letter(key_idx) == c) begin
            key_idx = key_idx + 4'd1;
        end else begin
            key_match = 1'b0;
        end
    endtask

    task automatic key_finish();
        in_len = key_match && key_idx == KEY_LEN && !len_seen;
        if (in_len) begin
            len_neg     = 1'b0;
            len_done    = 1'b0;
            len_started = 1'b0;
            len_acc     = '0;
        end
    endtask

    // decimal accumulation of the length value, saturating
    task automatic length_digit(input logic [7:0] c);
        longint unsigned v;
        if (!in_len || len_done) return;
        if (!len_started) begin
            if (space_ch(c)) return;
            len_started = 1'b1;
            if (c == CH_PLUS || c == CH_MINUS) begin
                len_neg = (c == CH_MINUS);
                return;
            end
        end
        if (digit_ch(c)) begin
            v = 64'(len_acc) * 64'd10 + 64'(c - 8'h30);
            len_acc = (v > LEN_MAX) ? LW'(LEN_MAX) : LW'(v);
        end else begin
            len_done = 1'b1;
        end
    endtask

    // one byte through the parser model
    task automatic parse_byte(input logic [7:0] c, input logic is_first, input logic is_last,
                              output t_result_word w);
        t_state was;
        t_tag   tag;
        logic   opens;
        logic   closes;
        if (is_first) clear_parser();
        was    = pst;
        tag    = TAG_NONE;
        opens  = 1'b0;
        closes = 1'b0;
        case (pst)
            ST_START: begin
                if (c == CH_CR || c == CH_LF || blank_ch(c)) begin
                end else if (upper_ch(c)) begin
                    tag = TAG_METHOD; opens = 1'b1; pst = ST_METHOD;
                end else begin
                    pst = ST_INVALID;
                end
            end
            ST_METHOD: begin
                if (upper_ch(c)) tag = TAG_METHOD;
                else if (blank_ch(c)) begin
                    closes = 1'b1; pst = ST_BEFORE_URI;
                end else pst = ST_INV_METHOD;
            end
            ST_BEFORE_URI: begin
                if (c == CH_SLASH) begin
                    tag = TAG_PATH; opens = 1'b1; pst = ST_URI;
                end else if (!blank_ch(c)) pst = ST_INVALID;
            end
            ST_URI: begin
                if (c == CH_QM) begin
                    closes = 1'b1; pst = ST_BEFORE_KEY;
                end else if (blank_ch(c)) begin
                    closes = 1'b1; pst = ST_BEFORE_PROTO;
                end else tag = TAG_PATH;
            end
            ST_BEFORE_KEY: begin
                if (blank_ch(c) || c == CH_LF || c == CH_CR) pst = ST_INV_URI;
                else begin
                    tag = TAG_QKEY; opens = 1'b1; pst = ST_KEY;
                end
            end
            ST_KEY: begin
                if (c == CH_EQ) begin
                    closes = 1'b1; pst = ST_BEFORE_VAL;
                end else if (blank_ch(c)) pst = ST_INV_URI;
                else tag = TAG_QKEY;
            end
            ST_BEFORE_VAL: begin
                if (blank_ch(c) || c == CH_LF || c == CH_CR) pst = ST_INV_URI;
                else begin
                    tag = TAG_QVAL; opens = 1'b1; pst = ST_VAL;
                end
            end
            ST_VAL: begin
                if (c == CH_AMP) begin
                    closes = 1'b1; pst = ST_BEFORE_KEY;
                end else if (blank_ch(c)) begin
                    closes = 1'b1; pst = ST_BEFORE_PROTO;
                end else tag = TAG_QVAL;
            end
            ST_BEFORE_PROTO: begin
                if (!blank_ch(c)) begin
                    tag = TAG_PROTO; opens = 1'b1; pst = ST_PROTO;
                end
            end
            ST_PROTO: begin
                if (c == CH_SLASH) begin
                    closes = 1'b1; pst = ST_BEFORE_VER;
                end else tag = TAG_PROTO;
            end
            ST_BEFORE_VER: begin
                if (digit_ch(c)) begin
                    tag = TAG_VERSION; opens = 1'b1; pst = ST_VER;
                end else pst = ST_INV_VERSION;
            end
            ST_VER: begin
                if (c == CH_CR) begin
                    closes = 1'b1; pst = ST_CR;
                end else if (c == CH_DOT) begin
                    tag = TAG_VERSION; pst = ST_VER_DOT;
                end else if (digit_ch(c)) tag = TAG_VERSION;
                else pst = ST_INV_VERSION;
            end
            ST_VER_DOT: begin
                if (digit_ch(c)) begin
                    tag = TAG_VERSION; pst = ST_VER;
                end else pst = ST_INV_VERSION;
            end
            ST_HKEY: begin
                if (blank_ch(c)) begin
                    closes = 1'b1; key_finish(); pst = ST_BEFORE_COLON;
                end else if (c == CH_COLON) begin
                    closes = 1'b1; key_finish(); pst = ST_AFTER_COLON;
                end else begin
                    tag = TAG_HKEY; key_advance(c);
                end
            end
            ST_BEFORE_COLON: begin
                if (c == CH_COLON) pst = ST_AFTER_COLON;
                else if (!blank_ch(c)) pst = ST_INV_HEADER;
            end
            ST_AFTER_COLON: begin
                // a carriage return here is already the first value byte
                if (!blank_ch(c)) begin
                    tag = TAG_HVAL; opens = 1'b1; length_digit(c); pst = ST_HVAL;
                end
            end
            ST_HVAL: begin
                if (c == CH_CR) begin
                    closes = 1'b1;
                    if (in_len) begin
                        len_seen = 1'b1;
                        in_len   = 1'b0;
                    end
                    pst = ST_CR;
                end else begin
                    tag = TAG_HVAL; length_digit(c);
                end
            end
            ST_CR: begin
                pst = (c == CH_LF) ? ST_CRLF : ST_INVALID;
            end
            ST_CRLF: begin
                if (c == CH_CR) pst = ST_CRLFCR;
                else if (blank_ch(c)) pst = ST_INVALID;
                else begin
                    tag       = TAG_HKEY;
                    opens     = 1'b1;
                    key_idx   = '0;
                    key_match = 1'b1;
                    in_len    = 1'b0;
                    key_advance(c);
                    pst       = ST_HKEY;
                end
            end
            ST_CRLFCR: begin
                // end of the header block decides how the body is framed
                if (c != CH_LF) pst = ST_INV_HEADER;
                else begin
                    hdr_done   = 1'b1;
                    body_begun = 1'b0;
                    if (len_seen) begin
                        if (!len_neg && len_acc != '0) begin
                            body_left = len_acc;
                            pst       = ST_BODY_LEN;
                        end else pst = ST_COMPLETE;
                    end else if (is_last) pst = ST_COMPLETE;
                    else pst = ST_BODY_END;
                end
            end
            ST_BODY_LEN: begin
                tag        = TAG_BODY;
                opens      = !body_begun;
                body_begun = 1'b1;
                if (body_left != '0) body_left = body_left - 1'b1;
                if (body_left == '0) pst = ST_COMPLETE;
            end
            ST_BODY_END: begin
                tag        = TAG_BODY;
                opens      = !body_begun;
                body_begun = 1'b1;
                if (is_last) pst = ST_COMPLETE;
            end
            default: begin
            end
        endcase

        w.echo     = c;
        w.tag      = tag;
        w.opens    = opens;
        w.closes   = closes;
        w.status   = status_of(pst);
        w.len_seen = len_seen;
        w.blen     = (hdr_done && len_seen && !len_neg) ? len_acc : '0;

        if (was != ST_COMPLETE && pst == ST_COMPLETE) completed_n++;
        if (status_of(was) == STAT_PARSING && w.status != STAT_PARSING
                && w.status != STAT_COMPLETE) rejected_n++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: word %0d %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, checked_n, name, want, got);
            err_count++;
        end
    endtask

    initial begin
        clear_parser();
        err_count   = 0;
        checked_n   = 0;
        completed_n = 0;
        rejected_n  = 0;
    end

    // sample accepted words on each edge, predict and compare in order
    always @(posedge i_clk) begin
        t_result_word fresh;
        t_result_word want;
        if (!i_rst_n) begin
            clear_parser();
            due_results.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                parse_byte(i_req.byte_value, i_req.first_byte, i_req.last_byte, fresh);
                due_results.push_back(fresh);
            end
            if (i_res.valid && i_res.ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result word byte 0x%0h arrived, expected none",
                             $time, i_res.byte_echo);
                    err_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("byte_echo", 32'(want.echo), 32'(i_res.byte_echo));
                    check_field("field_tag", 32'(want.tag), 32'(i_res.field_tag));
                    check_field("field_opens", 32'(want.opens), 32'(i_res.field_opens));
                    check_field("field_closes", 32'(want.closes), 32'(i_res.field_closes));
                    check_field("parse_status", 32'(want.status), 32'(i_res.parse_status));
                    check_field("length_header_seen", 32'(want.len_seen),
                                32'(i_res.length_header_seen));
                    check_field("body_length", 32'(want.blen), 32'(i_res.body_length));
                    checked_n++;
                end
            end
        end
        o_errors    <= err_count;
        o_pending   <= due_results.size();
        o_checked   <= checked_n;
        o_completed <= completed_n;
        o_rejected  <= rejected_n;
    end

endmodule

// ===== tb/sv/tb_http_request_byte_parser_top.sv =====
// testbench top: request stimulus, output stalls, run limit and verdict
module tb_http_request_byte_parser_top;
    import hrbp_pkg::*;

    localparam int RANDOM_BYTES = 1150;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int CYCLE_LIMIT  = 200000;

    localparam string UPPERS  = "ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam string DIGITS  = "0123456789";
    localparam string WORDCH  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_.~%";
    localparam string VALUECH = "abcdefxyzABCXYZ0123456789-_.~%,;/=()*:";

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    hrbp_in_if  req_if ();
    hrbp_out_if res_if ();

    int chk_errors;
    int chk_pending;
    int chk_checked;
    int chk_completed;
    int chk_rejected;

    logic [7:0] request_bytes[$];
    int         bytes_sent  = 0;
    int         burst_left  = 0;
    bit         offering    = 1'b0;
    int         hold_asked  = 0;
    int         cycle_count = 0;

    always #2 clk = ~clk;

    http_request_byte_parser_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    hrbp_result_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_if),
        .i_res       (res_if),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending),
        .o_checked   (chk_checked),
        .o_completed (chk_completed),
        .o_rejected  (chk_rejected)
    );

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: changing stall modes, plus a long hold-off on request
    initial begin
        int mode;
        int left;
        int held;
        mode = 0;
        left = 0;
        held = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (held != hold_asked) begin
                held = hold_asked;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(16, 120);
            end
            left--;
            case (mode)
                0:       res_if.ready <= 1'b1;
                1:       res_if.ready <= ($urandom_range(0, 9) < 7);
                2:       res_if.ready <= (left % 4 == 0);
                default: res_if.ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    function automatic logic [7:0] pick(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    // 0 cr, 1 lf, 2 space, 3 tab, 4 vt, 5 ff
    function automatic logic [7:0] ctrl_char(input int k);
        case (k)
            0:       return CH_CR;
            1:       return CH_LF;
            2:       return CH_SP;
            3:       return CH_TAB;
            4:       return 8'h0B;
            default: return 8'h0C;
        endcase
    endfunction

    task automatic add_text(input string s);
        foreach (s[i]) request_bytes.push_back(s[i]);
    endtask

    task automatic add_crlf();
        request_bytes.push_back(CH_CR);
        request_bytes.push_back(CH_LF);
    endtask

    task automatic add_word(input string set, input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) request_bytes.push_back(pick(set));
    endtask

    task automatic stop_offering();
        if (offering) begin
            req_if.valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // one word on the request channel; bursts with gaps between them
    task automatic send_byte(input logic [7:0] b, input logic is_first, input logic is_last);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
            stop_offering();
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        burst_left--;
        req_if.valid      <= 1'b1;
        req_if.byte_value <= b;
        req_if.first_byte <= is_first;
        req_if.last_byte  <= is_last;
        offering = 1'b1;
        do @(posedge clk); while (!req_if.ready);
        bytes_sent++;
    endtask

    task automatic send_request(input bit with_first, input bit stray_last);
        int n;
        n = request_bytes.size();
        for (int i = 0; i < n; i++) begin
            send_byte(request_bytes[i], with_first && i == 0,
                      i == n - 1 || (stray_last && $urandom_range(0, 39) == 0));
        end
    endtask

    // content-length value text; returns the length it asks for, -1 when huge
    task automatic add_length_value(output int asked);
        int form;
        int v;
        bit neg;
        asked = 0;
        neg   = 1'b0;
        // carriage return right after the colon opens the value
        if ($urandom_range(0, 7) == 0) request_bytes.push_back(CH_CR);
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 2)) request_bytes.push_back(ctrl_char($urandom_range(1, 5)));
        end
        case ($urandom_range(0, 5))
            0: request_bytes.push_back(CH_PLUS);
            1: begin
                request_bytes.push_back(CH_MINUS);
                neg = 1'b1;
            end
            default: begin
            end
        endcase
        form = $urandom_range(0, 9);
        if (form == 0) begin
            asked = 0;
        end else if (form == 1) begin
            add_word(DIGITS, 8, 12);
            asked = -1;
        end else begin
            v = $urandom_range(0, 10);
            if ($urandom_range(0, 5) == 0) request_bytes.push_back("0");
            add_text($sformatf("%0d", v));
            asked = v;
        end
        if (neg) asked = 0;
        if ($urandom_range(0, 3) == 0) request_bytes.push_back(pick(VALUECH));
    endtask

    // a request line, headers and a body, mostly well formed
    task automatic build_request();
        int  nhdr;
        int  asked;
        int  cl_len;
        int  nbody;
        int  pos;
        bit  cl_found;
        bit  is_len_key;
        request_bytes.delete();
        cl_found = 1'b0;
        cl_len   = 0;

        // plain noise now and then
        if ($urandom_range(0, 15) == 0) begin
            repeat ($urandom_range(1, 10)) request_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end

        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) request_bytes.push_back(ctrl_char($urandom_range(0, 3)));
        end
        add_word(UPPERS, 1, 5);
        repeat ($urandom_range(1, 2)) request_bytes.push_back(ctrl_char($urandom_range(2, 3)));
        request_bytes.push_back(CH_SLASH);
        repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 15) == 0) begin
                pos = $urandom_range(0, 255);
                if (pos == CH_SP || pos == CH_TAB || pos == CH_QM) pos = 8'hA5;
                request_bytes.push_back(8'(pos));
            end else begin
                request_bytes.push_back(pick(WORDCH));
            end
        end

        // query pairs
        if ($urandom_range(0, 2) == 0) begin
            request_bytes.push_back(CH_QM);
            nhdr = $urandom_range(1, 2);
            for (int k = 0; k < nhdr; k++) begin
                if (k != 0) request_bytes.push_back(CH_AMP);
                add_word(WORDCH, 1, 3);
                request_bytes.push_back(CH_EQ);
                add_word(WORDCH, 1, 3);
            end
        end

        repeat ($urandom_range(1, 2)) request_bytes.push_back(ctrl_char($urandom_range(2, 3)));
        if ($urandom_range(0, 3) != 0) add_text("HTTP");
        else add_word(WORDCH, 1, 4);
        request_bytes.push_back(CH_SLASH);
        add_word(DIGITS, 1, 2);
        if ($urandom_range(0, 2) != 0) begin
            request_bytes.push_back(CH_DOT);
            add_word(DIGITS, 1, 2);
        end
        add_crlf();

        // header lines
        nhdr = ($urandom_range(0, 7) == 0) ? 3 : $urandom_range(0, 2);
        repeat (nhdr) begin
            is_len_key = 1'b0;
            case ($urandom_range(0, 4))
                0, 1: begin
                    add_text("Content-Length");
                    is_len_key = 1'b1;
                end
                2: begin
                    case ($urandom_range(0, 3))
                        0:       add_text("Content-Lengths");
                        1:       add_text("Content-Lengt");
                        2:       add_text("content-length");
                        default: add_text("Content-Lenhth");
                    endcase
                end
                default: add_word(WORDCH, 1, 8);
            endcase
            if ($urandom_range(0, 3) == 0) request_bytes.push_back(ctrl_char($urandom_range(2, 3)));
            request_bytes.push_back(CH_COLON);
            repeat ($urandom_range(0, 2)) request_bytes.push_back(ctrl_char($urandom_range(2, 3)));
            if (is_len_key) begin
                add_length_value(asked);
                if (!cl_found) begin
                    cl_found = 1'b1;
                    cl_len   = asked;
                end
            end else begin
                request_bytes.push_back(pick(VALUECH));
                repeat ($urandom_range(0, 5)) begin
                    if ($urandom_range(0, 4) == 0) request_bytes.push_back(CH_SP);
                    else request_bytes.push_back(pick(VALUECH));
                end
            end
            add_crlf();
        end
        add_crlf();

        // body framed by the length, or running to the end of the buffer
        if (cl_found && cl_len < 0) nbody = $urandom_range(0, 6);
        else if (cl_found && cl_len == 0) nbody = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        else if (cl_found) nbody = ($urandom_range(0, 3) != 0) ? cl_len : $urandom_range(0, cl_len + 2);
        else nbody = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        repeat (nbody) request_bytes.push_back(8'($urandom_range(0, 255)));

        // broken requests: one corrupted byte or a buffer cut short
        case ($urandom_range(0, 7))
            0: request_bytes[$urandom_range(0, request_bytes.size() - 1)] = 8'($urandom_range(0, 255));
            1: begin
                pos = $urandom_range(1, request_bytes.size() - 1);
                while (request_bytes.size() > pos) void'(request_bytes.pop_back());
            end
            default: begin
            end
        endcase
    endtask

    // stimulus
    initial begin
        int req_no;
        int drain;
        req_if.valid      <= 1'b0;
        req_if.byte_value <= 8'h00;
        req_if.first_byte <= 1'b0;
        req_if.last_byte  <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extreme bytes then a held rejection
        request_bytes = '{8'h00, 8'hFF};
        send_request(1'b1, 1'b0);
        // shortest request, no length header, buffer ends on the final lf
        request_bytes.delete();
        add_text("A / P/1");
        add_crlf();
        add_crlf();
        send_request(1'b1, 1'b0);
        // bad method, bad uri, bad version
        request_bytes.delete();
        add_text("A1");
        send_request(1'b1, 1'b0);
        request_bytes.delete();
        add_text("G /? ");
        send_request(1'b1, 1'b0);
        request_bytes.delete();
        add_text("A / P/x");
        send_request(1'b1, 1'b0);

        // random requests
        req_no = 0;
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            req_no++;
            if (req_no == 5) begin
                // long output hold-off while input keeps coming
                hold_asked = hold_asked + 1;
                burst_left = 400;
            end
            if (req_no == 12) begin
                stop_offering();
                do @(posedge clk); while (chk_pending != 0);
            end
            build_request();
            send_request($urandom_range(0, 15) != 0, 1'b1);
        end
        stop_offering();

        // drain and settle
        drain = 0;
        do begin
            @(posedge clk);
            drain++;
        end while (chk_pending != 0 && drain < DRAIN_LIMIT);
        repeat (8) @(posedge clk);
        if (chk_pending != 0) begin
            $display("%0t: %0d expected result words never arrived", $time, chk_pending);
        end

        $display("run covered %0d random request bytes in %0d requests, %0d result words compared",
                 bytes_sent, req_no, chk_checked);
        $display("%0d requests reached complete and %0d were rejected", chk_completed,
                 chk_rejected);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
